// ----- rtl/slcd_pkg.sv -----
// ---------------------------------------------------------------------------
// slcd_pkg
// Shared types, codes and sizes for the segment LCD update engine.
// ---------------------------------------------------------------------------
package slcd_pkg;

  localparam int MAX_COMMONS   = 8;
  localparam int SEGMENT_COUNT = 64;
  localparam int MAP_DEPTH     = 64;
  localparam int MAP_IDX_W     = 6;
  localparam int COMMON_IDX_W  = (MAX_COMMONS > 1) ? $clog2(MAX_COMMONS) : 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  // physical segments that exist in a display word
  localparam logic [63:0] SEG_WORD_MASK = (SEGMENT_COUNT >= 64) ? {64{1'b1}} :
                                          ((64'd1 << SEGMENT_COUNT) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_SEGMENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE   = 2'd2;

  localparam logic [3:0] COMMON_COUNT_RESET = 4'd4;

  typedef enum logic [1:0] {
    FN_MAP_LOAD = 2'd0,
    FN_UPDATE   = 2'd1,
    FN_SYNC     = 2'd2,
    FN_DONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LOCKED  = 2'd2
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [2:0]  common_sel;
    logic [63:0] seg_mask;
    logic [63:0] seg_data;
    logic [5:0]  map_index;
    logic [5:0]  map_target;
  } in_req_t;

  typedef struct packed {
    status_t status;
    logic    ready_res;
  } out_rsp_t;

  typedef struct packed {
    logic capture;
    logic sweep_clear;
    logic sweep_run;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/slcd_dp.sv -----
// ---------------------------------------------------------------------------
// slcd_dp
// Datapath: config registers, segment map RAM, display words, sync lock,
// remap accumulator and result register.
// ---------------------------------------------------------------------------
module slcd_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  slcd_pkg::in_req_t               in_data,
  input  slcd_pkg::dp_cmd_t               cmd,
  output slcd_pkg::dp_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output slcd_pkg::out_rsp_t              out_data
);

  logic [3:0]  common_count_r;
  logic [63:0] valid_segments_r;
  logic        remap_enable_r;

  slcd_pkg::in_req_t item_r;

  logic [5:0] map_mem [slcd_pkg::MAP_DEPTH];
  logic [5:0] map_q_r;
  logic [slcd_pkg::MAP_IDX_W:0]   idx_r;
  logic [slcd_pkg::MAP_IDX_W-1:0] pidx_r;
  logic       pvalid_r;
  logic [63:0] pm_r;
  logic [63:0] pd_r;

  logic [slcd_pkg::SEGMENT_COUNT-1:0] words_r [slcd_pkg::MAX_COMMONS];
  logic sync_pending_r;

  logic        out_valid_r;
  slcd_pkg::out_rsp_t out_data_r;

  logic    sel_bad;
  logic    mask_bad;
  slcd_pkg::status_t upd_status;
  slcd_pkg::status_t item_status;
  logic    pending_nxt;
  logic    upd_write;
  logic [63:0] pm;
  logic [63:0] pd;
  logic [slcd_pkg::COMMON_IDX_W-1:0] wsel;
  logic [slcd_pkg::SEGMENT_COUNT-1:0] word_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_count_r   <= slcd_pkg::COMMON_COUNT_RESET;
      valid_segments_r <= '0;
      remap_enable_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slcd_pkg::CFG_COMMON_COUNT:   common_count_r   <= cfg_wdata[3:0];
        slcd_pkg::CFG_VALID_SEGMENTS: valid_segments_r <= cfg_wdata;
        slcd_pkg::CFG_REMAP_ENABLE:   remap_enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // request checks, in priority order
  always_comb begin
    sel_bad  = ({1'b0, item_r.common_sel} >= common_count_r) ||
               (32'(item_r.common_sel) >= slcd_pkg::MAX_COMMONS);
    mask_bad = |(item_r.seg_mask & ~(valid_segments_r & slcd_pkg::SEG_WORD_MASK));
    priority if (sel_bad || mask_bad) begin
      upd_status = slcd_pkg::ST_INVALID;
    end else if (sync_pending_r) begin
      upd_status = slcd_pkg::ST_LOCKED;
    end else begin
      upd_status = slcd_pkg::ST_OK;
    end
  end

  always_comb begin
    item_status = slcd_pkg::ST_OK;
    pending_nxt = sync_pending_r;
    unique case (item_r.func)
      slcd_pkg::FN_MAP_LOAD: ;
      slcd_pkg::FN_UPDATE:   item_status = upd_status;
      slcd_pkg::FN_SYNC: begin
        if (sync_pending_r) begin
          item_status = slcd_pkg::ST_LOCKED;
        end
        pending_nxt = 1'b1;
      end
      slcd_pkg::FN_DONE:     pending_nxt = 1'b0;
      default: ;
    endcase
  end

  assign upd_write = (item_r.func == slcd_pkg::FN_UPDATE) && (upd_status == slcd_pkg::ST_OK);

  // remap sweep: one map RAM read per cycle, scatter one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      pvalid_r <= 1'b0;
    end else if (cmd.sweep_clear) begin
      idx_r    <= '0;
      pvalid_r <= 1'b0;
    end else if (cmd.sweep_run) begin
      if (32'(idx_r) < slcd_pkg::MAP_DEPTH) begin
        idx_r    <= idx_r + 1'b1;
        pvalid_r <= 1'b1;
      end else begin
        pvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_run) begin
      map_q_r <= map_mem[idx_r[slcd_pkg::MAP_IDX_W-1:0]];
      pidx_r  <= idx_r[slcd_pkg::MAP_IDX_W-1:0];
    end
    if (cmd.commit && (item_r.func == slcd_pkg::FN_MAP_LOAD)) begin
      map_mem[item_r.map_index] <= item_r.map_target;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_clear) begin
      pm_r <= '0;
      pd_r <= '0;
    end else if (cmd.sweep_run && pvalid_r && item_r.seg_mask[pidx_r] &&
                 (32'(map_q_r) < slcd_pkg::SEGMENT_COUNT)) begin
      pm_r[map_q_r] <= 1'b1;
      pd_r[map_q_r] <= pd_r[map_q_r] | item_r.seg_data[pidx_r];
    end
  end

  // read-modify-write of the addressed display word
  always_comb begin
    pm       = remap_enable_r ? pm_r : item_r.seg_mask;
    pd       = remap_enable_r ? pd_r : item_r.seg_data;
    pm       = pm & slcd_pkg::SEG_WORD_MASK;
    wsel     = item_r.common_sel[slcd_pkg::COMMON_IDX_W-1:0];
    word_nxt = (words_r[wsel] & ~pm[slcd_pkg::SEGMENT_COUNT-1:0]) |
               (pm[slcd_pkg::SEGMENT_COUNT-1:0] & pd[slcd_pkg::SEGMENT_COUNT-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < slcd_pkg::MAX_COMMONS; i++) begin
        words_r[i] <= '0;
      end
      sync_pending_r <= 1'b0;
    end else if (cmd.commit) begin
      if (upd_write) begin
        words_r[wsel] <= word_nxt;
      end
      sync_pending_r <= pending_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.status    <= item_status;
      out_data_r.ready_res <= ~pending_nxt;
    end
  end

  assign stat.need_sweep = upd_write && remap_enable_r;
  assign stat.sweep_done = (32'(idx_r) == slcd_pkg::MAP_DEPTH) && !pvalid_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// ----- rtl/slcd_ctrl.sv -----
// ---------------------------------------------------------------------------
// slcd_ctrl
// Sequencer: take a request, check it, sweep the map if remapped, commit.
// ---------------------------------------------------------------------------
module slcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  slcd_pkg::dp_stat_t stat,
  output slcd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  always_comb begin
    cmd.capture     = (state_r == S_IDLE) && in_valid;
    cmd.sweep_clear = (state_r == S_CHECK) && stat.need_sweep;
    cmd.sweep_run   = (state_r == S_SWEEP);
    cmd.commit      = (state_r == S_COMMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_CHECK;
            in_stall_r <= 1'b1;
          end
        end
        S_CHECK: begin
          state_r <= stat.need_sweep ? S_SWEEP : S_COMMIT;
        end
        S_SWEEP: begin
          if (stat.sweep_done) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          // hold until the result register can take the result
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ----- rtl/segment_lcd_update_engine_top.sv -----
// ---------------------------------------------------------------------------
// segment_lcd_update_engine_top: an accepted request passes the check and commit states, and a remapped
// update also the map RAM sweep (one entry read per cycle over 64 entries), before its result is
// registered. One request is in flight at a time. A waiting result does not block entry.
// Reset (rst_n, synchronous): display words and sync lock cleared, config to defaults.
// ---------------------------------------------------------------------------
module segment_lcd_update_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  slcd_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output slcd_pkg::out_rsp_t              out_data,
  input  logic                            cfg_we,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  slcd_pkg::dp_cmd_t  cmd;
  slcd_pkg::dp_stat_t stat;

  slcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  slcd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // one request in flight at a time
  a_single_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while busy");

  // a commit never overwrites a result still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // a locked result always reports the lock still set
  a_locked_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == slcd_pkg::ST_LOCKED)) |-> !out_data.ready_res)
    else $error("locked status with ready set");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: segment LCD update engine testbench
// Runs a directed table of requests and register writes, then random
// requests under six register settings and three handshake idling profiles.
// Every response is checked, against the row's expected value where a
// directed row gives one, else against an in-bench model of the display memory, segment map and sync lock.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcd_pkg::*;

  localparam logic [63:0] ONES       = '1;
  localparam int          SETTLE     = 80;    // covers a remapped update
  localparam int          STALL_MAX  = 2000;  // cycles without any handshake
  localparam int          PHASE_REQS = 75;

  typedef enum logic {K_REQ, K_CFG} row_kind_t;

  // cfg rows: idx holds the register index, mask holds the write value
  typedef struct packed {
    row_kind_t   kind;
    func_t       func;
    logic [2:0]  sel;
    logic [63:0] mask;
    logic [63:0] data;
    logic [5:0]  idx;
    logic [5:0]  tgt;
    logic        typed;
    status_t     st;
    logic        rdy;
  } dir_row_t;

  localparam dir_row_t DIRECTED [27] = '{
    '{K_REQ, FN_UPDATE,   3'd0, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_OK,      1'b1},
    '{K_REQ, FN_UPDATE,   3'd0, 64'h1, 64'h1, 6'd0,  6'd0,  1'b1, ST_INVALID, 1'b1},
    '{K_REQ, FN_UPDATE,   3'd4, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_INVALID, 1'b1},
    '{K_REQ, FN_UPDATE,   3'd7, ONES,  ONES,  6'd0,  6'd0,  1'b1, ST_INVALID, 1'b1},
    '{K_REQ, FN_DONE,     3'd0, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_OK,      1'b1},
    '{K_REQ, FN_SYNC,     3'd0, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_OK,      1'b0},
    '{K_REQ, FN_SYNC,     3'd0, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_LOCKED,  1'b0},
    '{K_REQ, FN_UPDATE,   3'd3, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_LOCKED,  1'b0},
    '{K_REQ, FN_UPDATE,   3'd3, ONES,  64'h0, 6'd0,  6'd0,  1'b1, ST_INVALID, 1'b0},
    '{K_REQ, FN_MAP_LOAD, 3'd0, 64'h0, 64'h0, 6'd63, 6'd0,  1'b1, ST_OK,      1'b0},
    '{K_REQ, FN_DONE,     3'd0, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_OK,      1'b1},
    '{K_CFG, FN_MAP_LOAD, 3'd0, ONES,  64'h0, 6'(CFG_VALID_SEGMENTS), 6'd0,
      1'b0, ST_OK, 1'b0},
    '{K_CFG, FN_MAP_LOAD, 3'd0, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0, 6'(CFG_COMMON_COUNT),
      6'd0, 1'b0, ST_OK, 1'b0},
    '{K_REQ, FN_UPDATE,   3'd7, ONES,  ONES,  6'd0,  6'd0,  1'b1, ST_OK,      1'b1},
    '{K_REQ, FN_UPDATE,   3'd0, ONES,  64'h0, 6'd0,  6'd0,  1'b1, ST_OK,      1'b1},
    '{K_REQ, FN_MAP_LOAD, 3'd0, 64'h0, 64'h0, 6'd0,  6'd63, 1'b1, ST_OK,      1'b1},
    '{K_REQ, FN_MAP_LOAD, 3'd0, 64'h0, 64'h0, 6'd21, 6'd42, 1'b0, ST_OK,      1'b0},
    '{K_REQ, FN_UPDATE,   3'd5, 64'h5555_5555_5555_5555, 64'hA5A5_A5A5_A5A5_A5A5,
      6'd0, 6'd0, 1'b0, ST_OK, 1'b0},
    '{K_CFG, FN_MAP_LOAD, 3'd0, 64'h0, 64'h0, 6'(CFG_COMMON_COUNT), 6'd0,
      1'b0, ST_OK, 1'b0},
    '{K_REQ, FN_UPDATE,   3'd0, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_INVALID, 1'b1},
    '{K_CFG, FN_MAP_LOAD, 3'd0, 64'h1, 64'h0, 6'(CFG_COMMON_COUNT), 6'd0,
      1'b0, ST_OK, 1'b0},
    '{K_CFG, FN_MAP_LOAD, 3'd0, 64'h8000_0000_0000_0001, 64'h0,
      6'(CFG_VALID_SEGMENTS), 6'd0, 1'b0, ST_OK, 1'b0},
    '{K_REQ, FN_UPDATE,   3'd0, 64'h8000_0000_0000_0001, ONES, 6'd0, 6'd0,
      1'b0, ST_OK, 1'b0},
    '{K_REQ, FN_UPDATE,   3'd1, 64'h0, 64'h0, 6'd0,  6'd0,  1'b1, ST_INVALID, 1'b1},
    '{K_REQ, FN_UPDATE,   3'd0, 64'h2, 64'h0, 6'd0,  6'd0,  1'b1, ST_INVALID, 1'b1},
    '{K_CFG, FN_MAP_LOAD, 3'd0, 64'hF, 64'h0, 6'(CFG_COMMON_COUNT), 6'd0,
      1'b0, ST_OK, 1'b0},
    '{K_REQ, FN_UPDATE,   3'd7, 64'h1, 64'h0, 6'd0,  6'd0,  1'b0, ST_OK,      1'b0}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  segment_lcd_update_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the engine state and registers
  logic [63:0] shadow_words [MAX_COMMONS];
  logic [5:0]  shadow_map [MAP_DEPTH];
  logic [63:0] map_loaded;
  logic        shadow_lock;
  logic [3:0]  shadow_cc;
  logic [63:0] shadow_vs;
  logic        shadow_remap;

  out_rsp_t pending_rsp [$];
  int       tx_idle = 14;
  int       rx_idle = 52;
  int       mismatches = 0;
  int       reqs_sent = 0;
  int       rsps_checked = 0;
  int       locked_seen = 0;
  int       remapped_updates = 0;

  initial begin
    foreach (shadow_words[i]) shadow_words[i] = '0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    map_loaded   = '0;
    shadow_lock  = 1'b0;
    shadow_cc    = COMMON_COUNT_RESET;
    shadow_vs    = '0;
    shadow_remap = 1'b0;
  end

  // Apply one request to the shadow state and return its response.
  function automatic out_rsp_t lcd_apply_req(input in_req_t r);
    out_rsp_t    rsp;
    logic [63:0] pm;
    logic [63:0] pd;
    logic [5:0]  tgt;
    rsp.status = ST_OK;
    case (r.func)
      FN_MAP_LOAD: begin
        shadow_map[r.map_index] = r.map_target;
        map_loaded[r.map_index] = 1'b1;
      end
      FN_UPDATE: begin
        if ({1'b0, r.common_sel} >= shadow_cc || 32'(r.common_sel) >= MAX_COMMONS)
          rsp.status = ST_INVALID;
        else if ((r.seg_mask & ~(shadow_vs & SEG_WORD_MASK)) != 64'h0)
          rsp.status = ST_INVALID;
        else if (shadow_lock)
          rsp.status = ST_LOCKED;
        else begin
          if (shadow_remap) begin
            pm = '0;
            pd = '0;
            for (int i = 0; i < 64; i++) begin
              tgt = shadow_map[i];
              if (r.seg_mask[i] && 32'(tgt) < SEGMENT_COUNT) begin
                pm[tgt] = 1'b1;
                pd[tgt] = pd[tgt] | r.seg_data[i];
              end
            end
            remapped_updates++;
          end else begin
            pm = r.seg_mask;
            pd = r.seg_data;
          end
          pm = pm & SEG_WORD_MASK;
          shadow_words[r.common_sel] = (shadow_words[r.common_sel] & ~pm) | (pm & pd);
        end
      end
      FN_SYNC: begin
        if (shadow_lock)
          rsp.status = ST_LOCKED;
        else
          shadow_lock = 1'b1;
      end
      default: shadow_lock = 1'b0;
    endcase
    if (rsp.status == ST_LOCKED) locked_seen++;
    rsp.ready_res = ~shadow_lock;
    return rsp;
  endfunction

  function automatic in_req_t make_random_req();
    in_req_t  r;
    int       pick;
    int       lim;
    r.func       = func_t'($urandom_range(0, 3));
    r.common_sel = 3'($urandom_range(0, 7));
    r.seg_mask   = {$urandom, $urandom};
    r.seg_data   = {$urandom, $urandom};
    r.map_index  = 6'($urandom_range(0, 63));
    r.map_target = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 15)
      r.func = FN_MAP_LOAD;
    else if (pick < 25)
      r.func = FN_SYNC;
    else if (pick < 40)
      r.func = FN_DONE;
    else begin
      r.func = FN_UPDATE;
      lim = (shadow_cc > MAX_COMMONS) ? MAX_COMMONS : int'(shadow_cc);
      if (lim != 0 && $urandom_range(0, 3) != 0)
        r.common_sel = 3'($urandom_range(0, lim - 1));
      case ($urandom_range(0, 9))
        0:       r.seg_mask = '0;
        1:       r.seg_mask = shadow_vs;
        2, 3:    ;  // mostly out of the valid set
        default: r.seg_mask = r.seg_mask & shadow_vs;
      endcase
      // never route through a map entry that was not loaded
      if (shadow_remap) r.seg_mask = r.seg_mask & map_loaded;
    end
    return r;
  endfunction

  task automatic send_req(input in_req_t req, input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t rsp;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = lcd_apply_req(req);
    pending_rsp.push_back(typed ? typed_rsp : rsp);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COMMON_COUNT:   shadow_cc    = val[3:0];
      CFG_VALID_SEGMENTS: shadow_vs    = val;
      CFG_REMAP_ENABLE:   shadow_remap = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle);
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: status %0d ready_res %0d",
               out_data.status, out_data.ready_res);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        rsps_checked++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.ready_res !== want.ready_res) begin
          $error("ready_res: expected %0d, actual %0d", want.ready_res, out_data.ready_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: timeout, no handshake for %0d cycles", STALL_MAX);
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_req_t  req;
    out_rsp_t typed_rsp;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == K_CFG)
        cfg_write(DIRECTED[i].idx[CFG_IDX_W-1:0], DIRECTED[i].mask);
      else begin
        req.func       = DIRECTED[i].func;
        req.common_sel = DIRECTED[i].sel;
        req.seg_mask   = DIRECTED[i].mask;
        req.seg_data   = DIRECTED[i].data;
        req.map_index  = DIRECTED[i].idx;
        req.map_target = DIRECTED[i].tgt;
        typed_rsp.status    = DIRECTED[i].st;
        typed_rsp.ready_res = DIRECTED[i].rdy;
        send_req(req, DIRECTED[i].typed, typed_rsp);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0:       begin tx_idle = 14; rx_idle = 52; end
        1:       begin tx_idle = 52; rx_idle = 14; end
        default: begin tx_idle = 0;  rx_idle = 0;  end
      endcase
      case (p)
        0: begin
          cfg_write(CFG_COMMON_COUNT, 64'($urandom_range(1, 8)));
          cfg_write(CFG_VALID_SEGMENTS, {$urandom, $urandom});
          cfg_write(CFG_REMAP_ENABLE, 64'h0);
        end
        1, 4: begin
          cfg_write(CFG_COMMON_COUNT, 64'd8);
          cfg_write(CFG_VALID_SEGMENTS, ONES);
          cfg_write(CFG_REMAP_ENABLE, 64'h1);
        end
        2: begin
          cfg_write(CFG_COMMON_COUNT, 64'($urandom_range(1, 8)));
          cfg_write(CFG_VALID_SEGMENTS, {$urandom, $urandom});
          cfg_write(CFG_REMAP_ENABLE, 64'h1);
        end
        3: begin
          cfg_write(CFG_COMMON_COUNT, 64'd1);
          cfg_write(CFG_VALID_SEGMENTS, {$urandom, $urandom} & {$urandom, $urandom});
          cfg_write(CFG_REMAP_ENABLE, 64'h0);
        end
        default: begin
          cfg_write(CFG_COMMON_COUNT, 64'($urandom_range(0, 15)));
          cfg_write(CFG_VALID_SEGMENTS, {$urandom, $urandom});
          cfg_write(CFG_REMAP_ENABLE, 64'($urandom_range(0, 1)));
        end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        req = make_random_req();
        // fill the whole map before remapping is ever enabled
        if (p == 0 && n < MAP_DEPTH) begin
          req.func      = FN_MAP_LOAD;
          req.map_index = 6'(n);
        end
        send_req(req, 1'b0, '0);
        // hold the sender until every response is back
        if (n == PHASE_REQS / 2) drain();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("tb: %0d requests sent, %0d responses checked, %0d mismatches",
             reqs_sent, rsps_checked, mismatches);
    $display("tb: %0d remapped updates, %0d locked responses, 6 register settings",
             remapped_updates, locked_seen);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/slcd_pkg.sv
rtl/slcd_dp.sv
rtl/slcd_ctrl.sv
rtl/segment_lcd_update_engine_top.sv
tb/sv/tb.sv
